FILE: design/ovd_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package ovd_pkg;

	// Format codes in the top two bits of the first operand byte.
	localparam logic [1:0] FMT_POS   = 2'b00;
	localparam logic [1:0] FMT_NEG   = 2'b01;
	localparam logic [1:0] FMT_SHORT = 2'b10;
	localparam logic [1:0] FMT_LONG  = 2'b11;

	// Value lengths in bytes; zero means no value is being gathered.
	localparam logic [2:0] LEN_IDLE  = 3'd0;
	localparam logic [2:0] LEN_ONE   = 3'd1;
	localparam logic [2:0] LEN_SHORT = 3'd2;
	localparam logic [2:0] LEN_LONG  = 3'd4;

	// Offsets that turn a gathered operand field into its negative value.
	localparam logic [31:0] ADJ_SHORT = 32'h0000_4000;
	localparam logic [31:0] ADJ_LONG  = 32'h4000_0000;

	// Result status codes.
	localparam logic STATUS_OK    = 1'b0;
	localparam logic STATUS_TRUNC = 1'b1;

	// Values given for a value cut short by the end of the buffer.
	localparam logic [31:0] TRUNC_OPERAND = 32'hFFFF_FFFF;
	localparam logic [31:0] TRUNC_WORD    = 32'h0000_0000;

	typedef struct packed {
		logic [7:0] in_byte;
		logic       word_mode;
		logic       end_of_buffer;
	} in_word_t;

	typedef struct packed {
		logic signed [31:0] value;
		logic [2:0]         byte_count;
		logic               status;
	} out_word_t;

	// Outcome of one decode step, handed to the result register.
	typedef struct packed {
		logic      emit;
		out_word_t word;
	} step_t;

endpackage

`default_nettype wire

FILE: design/ovd_in_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface ovd_in_if;
	import ovd_pkg::*;

	logic     valid;
	logic     ready;
	in_word_t payload;

	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);

endinterface

`default_nettype wire

FILE: design/ovd_out_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface ovd_out_if;
	import ovd_pkg::*;

	logic      valid;
	logic      ready;
	out_word_t payload;

	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);

endinterface

`default_nettype wire

FILE: design/ovd_in_stage.sv
`timescale 1ns / 1ps
`default_nettype none

module ovd_in_stage (
	input  wire             clk,
	input  wire             arst_n,
	ovd_in_if.sink          in_chan,
	input  wire             advance,
	output logic            item_valid,
	output ovd_pkg::in_word_t item
);
	import ovd_pkg::*;

	logic     valid_s1;
	in_word_t word_s1;

	// The stage takes a word when it is empty or its word moves on.
	assign in_chan.ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_chan.valid && in_chan.ready) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_chan.valid && in_chan.ready) begin
			word_s1 <= in_chan.payload;
		end
	end

	assign item_valid = valid_s1;
	assign item       = word_s1;

endmodule

`default_nettype wire

FILE: design/ovd_decode.sv
`timescale 1ns / 1ps
`default_nettype none

module ovd_decode (
	input  wire               clk,
	input  wire               arst_n,
	input  wire               fire,
	input  ovd_pkg::in_word_t item,
	output ovd_pkg::step_t    step
);
	import ovd_pkg::*;

	logic [31:0] acc_q,    acc_d;
	logic [1:0]  held_q,   held_d;
	logic [2:0]  needed_q, needed_d;
	logic        mode_q,   mode_d;
	logic        sign_q,   sign_d;

	logic [31:0] acc_shift;
	logic [2:0]  got;

	assign acc_shift = {acc_q[23:0], item.in_byte};
	assign got       = {1'b0, held_q} + 3'd1;

	// One byte of the stream against the gathered state.
	always_comb begin
		acc_d     = acc_q;
		held_d    = held_q;
		needed_d  = needed_q;
		mode_d    = mode_q;
		sign_d    = sign_q;
		step.emit = 1'b0;
		step.word = '0;

		if (needed_q == LEN_IDLE) begin
			// First byte of a value: pick the format.
			mode_d = item.word_mode;
			held_d = 2'd1;
			sign_d = 1'b0;
			acc_d  = {24'b0, item.in_byte};
			if (item.word_mode) begin
				needed_d = LEN_LONG;
			end else begin
				acc_d  = {26'b0, item.in_byte[5:0]};
				sign_d = item.in_byte[5];
				unique case (item.in_byte[7:6])
					FMT_POS: begin
						needed_d        = LEN_IDLE;
						step.emit       = 1'b1;
						step.word.value = {24'b0, item.in_byte};
						step.word.byte_count = LEN_ONE;
						step.word.status     = STATUS_OK;
					end
					FMT_NEG: begin
						needed_d        = LEN_IDLE;
						step.emit       = 1'b1;
						step.word.value = {{25{1'b1}}, item.in_byte[6:0]};
						step.word.byte_count = LEN_ONE;
						step.word.status     = STATUS_OK;
					end
					FMT_SHORT: begin
						needed_d = LEN_SHORT;
					end
					FMT_LONG: begin
						needed_d = LEN_LONG;
					end
					default: begin
						needed_d = LEN_IDLE;
					end
				endcase
			end
			// A multi-byte value that starts on the last byte is cut short.
			if (item.end_of_buffer && needed_d != LEN_IDLE) begin
				needed_d             = LEN_IDLE;
				step.emit            = 1'b1;
				step.word.value      = item.word_mode ? TRUNC_WORD : TRUNC_OPERAND;
				step.word.byte_count = LEN_ONE;
				step.word.status     = STATUS_TRUNC;
			end
		end else begin
			// Later byte: shift it in and finish the value when it is whole.
			acc_d = acc_shift;
			if (got >= needed_q) begin
				needed_d             = LEN_IDLE;
				step.emit            = 1'b1;
				step.word.byte_count = needed_q;
				step.word.status     = STATUS_OK;
				if (!mode_q && sign_q) begin
					step.word.value = acc_shift -
						((needed_q == LEN_SHORT) ? ADJ_SHORT : ADJ_LONG);
				end else begin
					step.word.value = acc_shift;
				end
			end else if (item.end_of_buffer) begin
				needed_d             = LEN_IDLE;
				step.emit            = 1'b1;
				step.word.value      = mode_q ? TRUNC_WORD : TRUNC_OPERAND;
				step.word.byte_count = got;
				step.word.status     = STATUS_TRUNC;
			end else begin
				held_d = got[1:0];
			end
		end

		// Returning to idle clears the gathered state.
		if (needed_d == LEN_IDLE) begin
			acc_d  = '0;
			held_d = '0;
			mode_d = 1'b0;
			sign_d = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q    <= '0;
			held_q   <= '0;
			needed_q <= LEN_IDLE;
			mode_q   <= 1'b0;
			sign_q   <= 1'b0;
		end else if (fire) begin
			acc_q    <= acc_d;
			held_q   <= held_d;
			needed_q <= needed_d;
			mode_q   <= mode_d;
			sign_q   <= sign_d;
		end
	end

`ifndef SYNTHESIS
	a_len_legal: assert property (@(posedge clk) disable iff (!arst_n)
		needed_q == LEN_IDLE || needed_q == LEN_SHORT || needed_q == LEN_LONG)
		else $error("value length holds an illegal code");

	a_held_range: assert property (@(posedge clk) disable iff (!arst_n)
		needed_q != LEN_IDLE |-> held_q != 2'd0 && {1'b0, held_q} < needed_q)
		else $error("byte count out of range for a value in progress");

	a_eob_idle: assert property (@(posedge clk) disable iff (!arst_n)
		fire && item.end_of_buffer |=> needed_q == LEN_IDLE)
		else $error("decoder not idle after the last byte of the buffer");

	a_eob_emits: assert property (@(posedge clk) disable iff (!arst_n)
		fire && item.end_of_buffer |-> step.emit)
		else $error("last byte of the buffer gave no result");

	a_trunc_value: assert property (@(posedge clk) disable iff (!arst_n)
		step.emit && step.word.status == STATUS_TRUNC |->
		step.word.value == TRUNC_WORD || step.word.value == TRUNC_OPERAND)
		else $error("truncated result carries a decoded value");
`endif

endmodule

`default_nettype wire

FILE: design/ovd_out_stage.sv
`timescale 1ns / 1ps
`default_nettype none

module ovd_out_stage (
	input  wire            clk,
	input  wire            arst_n,
	ovd_out_if.source      out_chan,
	input  wire            fire,
	input  ovd_pkg::step_t step,
	output logic           advance
);
	import ovd_pkg::*;

	logic      valid_q;
	out_word_t word_q;

	// The register can take a new result when empty or being emptied.
	assign advance = !valid_q || out_chan.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (advance) begin
			valid_q <= fire && step.emit;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && fire && step.emit) begin
			word_q <= step.word;
		end
	end

	assign out_chan.valid   = valid_q;
	assign out_chan.payload = word_q;

endmodule

`default_nettype wire

FILE: design/operand_varint_decoder.sv
`timescale 1ns / 1ps
`default_nettype none

// Decodes signed integers from a stream of bytes, one byte per word on
// in_chan. The first byte of each value samples word_mode: in operand mode the
// top two bits of that byte give a one-byte value, a two-byte 14-bit value or
// a four-byte 30-bit value; in word mode four big-endian bytes form a 32-bit
// value. Each finished value gives one word on out_chan with the sign-extended
// value, the bytes it took and a status; end_of_buffer on a byte that does not
// finish a value gives a truncated result (value -1 in operand mode, 0 in word
// mode). A byte passes an input register and the decode logic into the result
// register, which offers the result on out_chan. One byte is taken every
// cycle while the result register is empty or its word is being taken; a
// result that out_chan leaves waiting stalls the input once the input register
// also holds a byte.
module operand_varint_decoder (
	input  wire       clk,
	input  wire       arst_n,
	ovd_in_if.sink    in_chan,
	ovd_out_if.source out_chan
);
	import ovd_pkg::*;

	logic     item_valid;
	in_word_t item;
	logic     advance;
	logic     fire;
	step_t    step;

	assign fire = item_valid && advance;

	ovd_in_stage u_in_stage (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_chan    (in_chan),
		.advance    (advance),
		.item_valid (item_valid),
		.item       (item)
	);

	ovd_decode u_decode (
		.clk    (clk),
		.arst_n (arst_n),
		.fire   (fire),
		.item   (item),
		.step   (step)
	);

	ovd_out_stage u_out_stage (
		.clk      (clk),
		.arst_n   (arst_n),
		.out_chan (out_chan),
		.fire     (fire),
		.step     (step),
		.advance  (advance)
	);

endmodule

`default_nettype wire
